// ===== src/wir_pkg.sv =====
// Package for the 3x3 wall interior removal block.
// Holds size constants, the register map, the stage-one pipeline type and the size clamp.
// No dependencies.
package wir_pkg;

	// Largest image the line stores can hold
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;

	// Field and counter widths
	localparam int COLOR_W   = 32;
	localparam int SIZE_W    = 11;
	localparam int CFG_IDX_W = 2;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int OUT_ROW_W = $clog2(MAX_HEIGHT);
	// Input row runs one past the last row while the frame is flushed
	localparam int DIM_W     = $clog2(MAX_DIM + 2);

	localparam int RESET_WIDTH  = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
	localparam int RESET_HEIGHT = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

	// Register map of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WALL_COLOR    = 2'd0,
		REG_NEUTRAL_COLOR = 2'd1,
		REG_IMAGE_WIDTH   = 2'd2,
		REG_IMAGE_HEIGHT  = 2'd3
	} cfg_reg_t;

	// Item held between the memory read and the output register.
	// row_ok / col_ok index 0 = top / left, 1 = centre, 2 = bottom / right.
	typedef struct packed {
		logic               store;
		logic               produce;
		logic               last;
		logic [COL_W-1:0]   col;
		logic               wall;
		logic [COLOR_W-1:0] color;
		logic [2:0]         row_ok;
		logic [2:0]         col_ok;
	} stage1_t;

	// Clamp a written size to 1..maxv (zero acts as one)
	function automatic logic [DIM_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
			input int unsigned maxv);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (32'(v) > maxv) begin
			r = DIM_W'(maxv);
		end else begin
			r = DIM_W'(v);
		end
		return r;
	endfunction

endpackage

// ===== src/wall_interior_removal_3x3.sv =====
// Top level of the 3x3 wall interior removal block.
// Line stores for wall flags and colours, 3x3 window and output register; uses wir_pkg.
//
// Takes one RGBA pixel per clock in raster order and, while the output is not stalled,
// gives one cleaned pixel per clock, replacing every wall pixel whose eight neighbours
// are all wall by the neutral colour. Neighbours outside the image, in row 0 or in
// column 0 count as wall. A result leaves one row plus one pixel behind the input, so
// after the last pixel of a frame width+1 pad transactions (tuser set) must follow to
// flush it; pads at any other time are dropped. Width and height are sampled with the
// first pixel of a frame. Each accepted transaction passes through the stage-one read of
// the column-indexed line stores, and the result for a completed window is then held in
// the output register; a new transaction is taken every cycle while the output drains.
module wall_interior_removal_3x3
	import wir_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [COLOR_W-1:0]   cfg_wdata,
	// pixel input
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [COLOR_W-1:0]   s_tdata,   // [31:0] pixel_color
	input  logic [0:0]           s_tuser,   // [0] is_pad
	// cleaned pixel output
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [COLOR_W-1:0]   m_tdata,   // [31:0] out_color
	output logic                 m_tlast    // out_last
);

	// Configuration registers
	logic [COLOR_W-1:0] wall_color_q;
	logic [COLOR_W-1:0] neutral_color_q;
	logic [SIZE_W-1:0]  image_width_q;
	logic [SIZE_W-1:0]  image_height_q;

	// Frame position and latched size
	logic [COL_W-1:0]     in_col_q;
	logic [DIM_W-1:0]     in_row_q;
	logic [COL_W-1:0]     out_col_q;
	logic [OUT_ROW_W-1:0] out_row_q;
	logic [DIM_W-1:0]     fw_q;
	logic [DIM_W-1:0]     fh_q;

	// Line stores: two rows of wall flags and one row of colours, by column
	logic [1:0]         flag_mem [MAX_WIDTH];
	logic [COLOR_W-1:0] color_mem [MAX_WIDTH];

	// Stage one
	logic               valid_s1;
	stage1_t            pipe_s1;
	logic [1:0]         flag_rd_s1;
	logic [COLOR_W-1:0] color_rd_s1;
	logic               fwd_s1;
	logic [1:0]         fwd_flag_s1;
	logic [COLOR_W-1:0] fwd_color_s1;

	// Window columns of earlier transactions
	logic [2:0]         prev1_q;
	logic [2:0]         prev2_q;
	logic [COLOR_W-1:0] prev_color_q;

	// Output register
	logic               out_valid_q;
	logic [COLOR_W-1:0] out_color_q;
	logic               out_last_q;

	// Input-side decode
	logic             pad;
	logic             idle;
	logic [DIM_W-1:0] w_eff;
	logic [DIM_W-1:0] h_eff;
	logic             pix_phase;
	logic             active;
	logic             produce;
	logic             last;
	logic             load;
	logic             s1_leave;
	stage1_t          pipe_d;

	// Stage-one decode
	logic [1:0]         flag_up;
	logic [COLOR_W-1:0] color_up;
	logic [2:0]         cur_col;
	logic [1:0]         flag_wr;
	logic               enclosed;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wall_color_q    <= '0;
			neutral_color_q <= '0;
			image_width_q   <= SIZE_W'(RESET_WIDTH);
			image_height_q  <= SIZE_W'(RESET_HEIGHT);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_WALL_COLOR:    wall_color_q    <= cfg_wdata;
				REG_NEUTRAL_COLOR: neutral_color_q <= cfg_wdata;
				REG_IMAGE_WIDTH:   image_width_q   <= cfg_wdata[SIZE_W-1:0];
				REG_IMAGE_HEIGHT:  image_height_q  <= cfg_wdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: stage one frees when its item leaves
	assign s1_leave = valid_s1 && (!pipe_s1.produce || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || s1_leave;
	assign load     = s_tvalid && s_tready;

	// Decode the incoming transaction against the frame position
	always_comb begin
		pad       = s_tuser[0];
		idle      = (in_row_q == '0) && (in_col_q == '0);
		w_eff     = idle ? clamp_size(image_width_q, MAX_WIDTH) : fw_q;
		h_eff     = idle ? clamp_size(image_height_q, MAX_HEIGHT) : fh_q;
		pix_phase = in_row_q < h_eff;
		active    = !pad || (!idle && !pix_phase);
		produce   = active && ((in_row_q >= DIM_W'(2)) ||
			((in_row_q == DIM_W'(1)) && (in_col_q != '0)));
		last      = produce && (DIM_W'(out_row_q) == h_eff - DIM_W'(1)) &&
			(DIM_W'(out_col_q) == w_eff - DIM_W'(1));

		pipe_d.store     = active && pix_phase;
		pipe_d.produce   = produce;
		pipe_d.last      = last;
		pipe_d.col       = in_col_q;
		pipe_d.wall      = s_tdata == wall_color_q;
		pipe_d.color     = s_tdata;
		pipe_d.row_ok[0] = out_row_q >= OUT_ROW_W'(2);
		pipe_d.row_ok[1] = out_row_q != '0;
		pipe_d.row_ok[2] = (DIM_W'(out_row_q) + DIM_W'(1)) < h_eff;
		pipe_d.col_ok[0] = out_col_q >= COL_W'(2);
		pipe_d.col_ok[1] = out_col_q != '0;
		pipe_d.col_ok[2] = (DIM_W'(out_col_q) + DIM_W'(1)) < w_eff;
	end

	// Advance the input and output positions; return to idle after the last result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			fw_q      <= DIM_W'(RESET_WIDTH);
			fh_q      <= DIM_W'(RESET_HEIGHT);
		end else if (load && active) begin
			if (idle) begin
				fw_q <= w_eff;
				fh_q <= h_eff;
			end
			if (last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if ((DIM_W'(in_col_q) + DIM_W'(1)) == w_eff) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + DIM_W'(1);
				end else begin
					in_col_q <= in_col_q + COL_W'(1);
				end
				if (produce) begin
					if ((DIM_W'(out_col_q) + DIM_W'(1)) == w_eff) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + OUT_ROW_W'(1);
					end else begin
						out_col_q <= out_col_q + COL_W'(1);
					end
				end
			end
		end
	end

	// Stage-one control: valid bit and forwarding flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else if (load) begin
			valid_s1 <= active;
			fwd_s1   <= s1_leave && pipe_s1.store && (pipe_s1.col == in_col_q);
		end else if (s1_leave) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage-one payload and line-store reads
	always_ff @(posedge clk) begin
		if (load) begin
			pipe_s1      <= pipe_d;
			flag_rd_s1   <= flag_mem[in_col_q];
			color_rd_s1  <= color_mem[in_col_q];
			fwd_flag_s1  <= flag_wr;
			fwd_color_s1 <= pipe_s1.color;
		end
	end

	// Take the pending write when it hits the column just read
	always_comb begin
		flag_up  = fwd_s1 ? fwd_flag_s1 : flag_rd_s1;
		color_up = fwd_s1 ? fwd_color_s1 : color_rd_s1;
		// bit 0 holds the row above, bit 1 the row above that
		flag_wr  = {flag_up[0], pipe_s1.wall};
		cur_col  = {pipe_s1.wall, flag_up[0], flag_up[1]};
	end

	// Write back the line stores as the item leaves stage one
	always_ff @(posedge clk) begin
		if (s1_leave && pipe_s1.store) begin
			flag_mem[pipe_s1.col]  <= flag_wr;
			color_mem[pipe_s1.col] <= pipe_s1.color;
		end
	end

	// Erosion test over the window; neighbours off the valid area count as wall
	always_comb begin
		logic [2:0] win [3];
		win[0]   = prev2_q;
		win[1]   = prev1_q;
		win[2]   = cur_col;
		enclosed = prev1_q[1];
		for (int j = 0; j < 3; j++) begin
			for (int i = 0; i < 3; i++) begin
				if (!(i == 1 && j == 1)) begin
					enclosed = enclosed &&
						(win[j][i] || !(pipe_s1.row_ok[i] && pipe_s1.col_ok[j]));
				end
			end
		end
	end

	// Shift the window by one column per item
	always_ff @(posedge clk) begin
		if (s1_leave) begin
			prev2_q      <= prev1_q;
			prev1_q      <= cur_col;
			prev_color_q <= color_up;
		end
	end

	// Output register: hold until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_leave && pipe_s1.produce) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_leave && pipe_s1.produce) begin
			out_color_q <= enclosed ? neutral_color_q : prev_color_q;
			out_last_q  <= pipe_s1.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_color_q;
	assign m_tlast  = out_last_q;

	// Input column stays inside the latched width during a frame
	a_in_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		!idle |-> (DIM_W'(in_col_q) < fw_q))
		else $error("input column beyond frame width");

	// Output position stays inside the latched frame
	a_out_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(DIM_W'(out_row_q) < fh_q) && (DIM_W'(out_col_q) < fw_q))
		else $error("output position beyond frame");

	// Once the last result is in stage one the counters are back at idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && pipe_s1.last |-> (in_row_q == '0) && (in_col_q == '0))
		else $error("frame not closed after last result");

	// A write to the column being read is always forwarded
	a_fwd_write: assert property (@(posedge clk) disable iff (!arst_n)
		load && s1_leave && pipe_s1.store && (pipe_s1.col == in_col_q) |=> fwd_s1)
		else $error("same-column write not forwarded");

endmodule
